>>> sv/mlfr_pkg.sv
// mlfr_pkg: shared types and constants of the motor link frame receiver
// no dependencies; used by the channel interfaces and the top level

package mlfr_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned BudgetW = 16;
  localparam int unsigned StatusW = 2;

  // configuration port
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 4;

  // configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_EXPECTED_TYPE = 2'd0,
    REG_MAX_PAYLOAD   = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } reg_idx_t;

  // register reset values
  localparam logic [ByteW-1:0]   ExpectedTypeRst = 8'd159;
  localparam logic [ByteW-1:0]   MaxPayloadRst   = 8'd16;
  localparam logic [BudgetW-1:0] TimeoutTicksRst = 16'd30;

  // length byte obfuscation: plen = 0xFF - len - 4
  localparam logic [ByteW-1:0] LenBias = 8'hFB;

  // input item kinds
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // frame end status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

endpackage

>>> sv/mlfr_if.sv
// mlfr_in_if / mlfr_out_if: valid/ready channels of the frame receiver
// depends on mlfr_pkg for field widths and codes

interface mlfr_in_if;
  import mlfr_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface mlfr_out_if;
  import mlfr_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_end;
  logic [ByteW-1:0]   payload_byte;
  logic [ByteW-1:0]   payload_index;
  logic [StatusW-1:0] status;

  modport source (output valid, output is_end, output payload_byte,
                  output payload_index, output status, input ready);
  modport sink   (input valid, input is_end, input payload_byte,
                  input payload_index, input status, output ready);
endinterface

>>> sv/motor_link_frame_receiver.sv
// motor_link_frame_receiver: hunts for a typed frame, emits payload bytes,
// checks the 16-bit additive checksum and a per-frame tick budget
// depends on mlfr_pkg and the channel interfaces in mlfr_if.sv
//
// output: the result of an accepted transaction is written into the output register
//   and appears there in the cycle after its acceptance
// throughput: one transaction per cycle while the output is not held back; the parser
//   state updates in one step, and the output register frees up in the cycle it is taken
// reset: synchronous active-low rst_n returns the parser to hunting, empties
//   the output register and loads the register defaults

module motor_link_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  mlfr_in_if.sink                       in_if,
  mlfr_out_if.source                    out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mlfr_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [mlfr_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [mlfr_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import mlfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHK_HI,
    PH_CHK_LO
  } phase_t;

  // configuration registers
  logic [ByteW-1:0]   expected_type_r;
  logic [ByteW-1:0]   max_payload_r;
  logic [BudgetW-1:0] timeout_ticks_r;

  // parser state
  phase_t             phase_r, phase_nxt;
  logic [SumW-1:0]    running_sum_r, running_sum_nxt;
  logic [ByteW-1:0]   bytes_left_r, bytes_left_nxt;
  logic [ByteW-1:0]   byte_pos_r, byte_pos_nxt;
  logic [ByteW-1:0]   first_chk_r, first_chk_nxt;
  logic [BudgetW-1:0] budget_left_r, budget_left_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_is_end_r, out_is_end_nxt;
  logic [ByteW-1:0]   out_byte_r, out_byte_nxt;
  logic [ByteW-1:0]   out_index_r, out_index_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               in_accept;
  logic               cfg_write;
  reg_idx_t           cfg_idx;
  logic [ByteW-1:0]   rx;
  logic [ByteW-1:0]   plen;
  logic [ByteW-1:0]   bytes_left_dec;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CfgAddrW-1:2]);

  // register read mux
  always_comb begin
    unique case (cfg_idx)
      REG_EXPECTED_TYPE: cfg_prdata = {{(CfgDataW-ByteW){1'b0}}, expected_type_r};
      REG_MAX_PAYLOAD:   cfg_prdata = {{(CfgDataW-ByteW){1'b0}}, max_payload_r};
      REG_TIMEOUT_TICKS: cfg_prdata = {{(CfgDataW-BudgetW){1'b0}}, timeout_ticks_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // register writes; unknown addresses are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_type_r <= ExpectedTypeRst;
      max_payload_r   <= MaxPayloadRst;
      timeout_ticks_r <= TimeoutTicksRst;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_EXPECTED_TYPE: expected_type_r <= cfg_pwdata[ByteW-1:0];
        REG_MAX_PAYLOAD:   max_payload_r   <= cfg_pwdata[ByteW-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_pwdata[BudgetW-1:0];
        default: ;
      endcase
    end
  end

  // take a new transaction whenever the output register is free or draining
  assign in_if.ready = ~out_valid_r | out_if.ready;
  assign in_accept   = in_if.valid & in_if.ready;

  assign rx             = in_if.rx_byte;
  assign plen           = LenBias - rx;
  assign bytes_left_dec = bytes_left_r - 8'd1;

  // parser next state and result
  always_comb begin
    phase_nxt       = phase_r;
    running_sum_nxt = running_sum_r;
    bytes_left_nxt  = bytes_left_r;
    byte_pos_nxt    = byte_pos_r;
    first_chk_nxt   = first_chk_r;
    budget_left_nxt = budget_left_r;

    // a taken result empties the register unless replaced below
    out_valid_nxt  = out_valid_r & ~out_if.ready;
    out_is_end_nxt = out_is_end_r;
    out_byte_nxt   = out_byte_r;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;

    if (in_accept) begin
      if (kind_t'(in_if.kind) == KIND_TICK) begin
        // ticks spend the budget only inside a frame
        if (phase_r != PH_HUNT) begin
          if (budget_left_r <= BudgetW'(1)) begin
            budget_left_nxt = '0;
            phase_nxt       = PH_HUNT;
            out_valid_nxt   = 1'b1;
            out_is_end_nxt  = 1'b1;
            out_byte_nxt    = '0;
            out_index_nxt   = byte_pos_r;
            out_status_nxt  = ST_TIMEOUT;
          end else begin
            budget_left_nxt = budget_left_r - BudgetW'(1);
          end
        end
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            running_sum_nxt = running_sum_r + {{(SumW-ByteW){1'b0}}, rx};
            byte_pos_nxt    = '0;
            if (plen > max_payload_r) begin
              phase_nxt      = PH_HUNT;
              out_valid_nxt  = 1'b1;
              out_is_end_nxt = 1'b1;
              out_byte_nxt   = '0;
              out_index_nxt  = '0;
              out_status_nxt = ST_TOO_LONG;
            end else begin
              bytes_left_nxt = plen;
              phase_nxt      = (plen != '0) ? PH_PAYLOAD : PH_CHK_HI;
            end
          end
          PH_PAYLOAD: begin
            running_sum_nxt = running_sum_r + {{(SumW-ByteW){1'b0}}, rx};
            byte_pos_nxt    = byte_pos_r + 8'd1;
            bytes_left_nxt  = bytes_left_dec;
            if (bytes_left_dec == '0) begin
              phase_nxt = PH_CHK_HI;
            end
            out_valid_nxt  = 1'b1;
            out_is_end_nxt = 1'b0;
            out_byte_nxt   = rx;
            out_index_nxt  = byte_pos_r;
            out_status_nxt = ST_OK;
          end
          PH_CHK_HI: begin
            first_chk_nxt = rx;
            phase_nxt     = PH_CHK_LO;
          end
          PH_CHK_LO: begin
            phase_nxt      = PH_HUNT;
            out_valid_nxt  = 1'b1;
            out_is_end_nxt = 1'b1;
            out_byte_nxt   = '0;
            out_index_nxt  = byte_pos_r;
            out_status_nxt = ((first_chk_r == running_sum_r[SumW-1:ByteW]) &&
                              (rx == running_sum_r[ByteW-1:0])) ? ST_OK : ST_BAD_SUM;
          end
          default: begin
            // hunting: a matching type byte opens a frame
            if (rx == expected_type_r) begin
              running_sum_nxt = {{(SumW-ByteW){1'b0}}, rx};
              budget_left_nxt = timeout_ticks_r;
              bytes_left_nxt  = '0;
              byte_pos_nxt    = '0;
              phase_nxt       = PH_LEN;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      running_sum_r <= '0;
      bytes_left_r  <= '0;
      byte_pos_r    <= '0;
      first_chk_r   <= '0;
      budget_left_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      running_sum_r <= running_sum_nxt;
      bytes_left_r  <= bytes_left_nxt;
      byte_pos_r    <= byte_pos_nxt;
      first_chk_r   <= first_chk_nxt;
      budget_left_r <= budget_left_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_is_end_r <= out_is_end_nxt;
    out_byte_r   <= out_byte_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.is_end        = out_is_end_r;
  assign out_if.payload_byte  = out_byte_r;
  assign out_if.payload_index = out_index_r;
  assign out_if.status        = out_status_r;

endmodule
